[rtl/kmlr_pkg.sv]
// shared types and constants of the key matrix layer report block
package kmlr_pkg;

   localparam int SLOTS  = 6;
   localparam int SLOT_W = 3;

   localparam logic [1:0] FUNC_SCAN      = 2'd0;
   localparam logic [1:0] FUNC_KEYMAP    = 2'd1;
   localparam logic [1:0] FUNC_LAYER_SW  = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] pressed_mask;
      logic [1:0]  table_layer;
      logic [3:0]  table_key;
      logic [7:0]  table_value;
   } req_type;

   typedef struct packed {
      logic [7:0] key_0;
      logic [7:0] key_1;
      logic [7:0] key_2;
      logic [7:0] key_3;
      logic [7:0] key_4;
      logic [7:0] key_5;
      logic [1:0] active_layer;
   } rsp_type;

endpackage

[rtl/kmlr_req_if.sv]
// valid/ready channel carrying request items
interface kmlr_req_if import kmlr_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/kmlr_rsp_if.sv]
// valid/ready channel carrying report items
interface kmlr_rsp_if import kmlr_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/key_matrix_layer_report_top.sv]
// key matrix scanner: keymap and layer-switch memories, six-key report builder
//
// A scan item passes through the states S_LS, S_KM and S_DONE. The pressed mask is walked
// one key position per cycle over the first N = min(ROWS*COLS, 16) positions, first
// through the layer-switch memory to form the active layer and mark the ordinary keys,
// then through the keymap memory at that layer to fill the six report slots, and S_DONE
// moves the report to the output register once any earlier report has left it. The next
// item is taken only after that. A keymap or layer-switch write item is taken in S_IDLE
// and gives no report. After reset a clearing pass zeroes both memories; no item is taken
// until it ends. A finished report waits in an output register while the next item is
// taken.
module key_matrix_layer_report_top
   import kmlr_pkg::*;
#(
   parameter int ROWS   = 4,
   parameter int COLS   = 4,
   parameter int LAYERS = 4
) (
   input logic        clock,
   input logic        reset,
   kmlr_req_if.sink   req_chan,
   kmlr_rsp_if.source rsp_chan
);

   localparam int NKEYS    = ROWS * COLS;
   localparam int KM_DEPTH = LAYERS * NKEYS;
   localparam int LIMIT    = (NKEYS < 16) ? NKEYS : 16;
   localparam int LS_AW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
   localparam int KM_AW    = (KM_DEPTH > 1) ? $clog2(KM_DEPTH) : 1;
   localparam int CLR_W    = $clog2(KM_DEPTH + 1);
   localparam int CW       = $clog2(LIMIT + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LS    = 3'd2;
   localparam logic [2:0] S_KM    = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [7:0]       km_mem_ff [KM_DEPTH];
   logic [1:0]       ls_mem_ff [NKEYS];
   logic [7:0]       km_q_ff;
   logic [1:0]       ls_q_ff;

   logic [2:0]       state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [LIMIT-1:0] mask_ff, mask_in;
   logic [LIMIT-1:0] ord_ff, ord_in;
   logic [1:0]       layer_ff, layer_in;
   logic             pend_ff, pend_in;
   logic             pressed_ff, pressed_in;
   logic             zero_ff, zero_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [7:0]       key_ff [SLOTS];
   logic [7:0]       key_in [SLOTS];
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             km_we, ls_we;
   logic [KM_AW-1:0] km_waddr, km_raddr;
   logic [LS_AW-1:0] ls_waddr, ls_raddr;
   logic [7:0]       km_wdata;
   logic [1:0]       ls_wdata;
   logic             req_take;
   logic             layer_ok;
   logic [7:0]       code;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign layer_ok       = int'(layer_ff) < LAYERS;
   assign code           = zero_ff ? 8'd0 : km_q_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      ord_in       = ord_ff;
      layer_in     = layer_ff;
      pend_in      = 1'b0;
      pressed_in   = pressed_ff;
      zero_in      = zero_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      km_we        = 1'b0;
      ls_we        = 1'b0;
      km_waddr     = KM_AW'(int'(req_chan.data.table_layer) * NKEYS
                            + int'(req_chan.data.table_key));
      ls_waddr     = LS_AW'(req_chan.data.table_key);
      km_wdata     = req_chan.data.table_value;
      ls_wdata     = req_chan.data.table_value[1:0];
      km_raddr     = KM_AW'(int'(layer_ff) * NKEYS + int'(cnt_ff));
      ls_raddr     = LS_AW'(cnt_ff);

      case (state_ff)
         S_CLEAR: begin
            km_we    = 1'b1;
            km_waddr = KM_AW'(clr_ff);
            km_wdata = 8'd0;
            ls_we    = int'(clr_ff) < NKEYS;
            ls_waddr = LS_AW'(clr_ff);
            ls_wdata = 2'd0;
            clr_in   = clr_ff + 1'b1;
            if (int'(clr_ff) == KM_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               case (req_chan.data.func)
                  FUNC_SCAN: begin
                     state_in = S_LS;
                     cnt_in   = '0;
                     mask_in  = req_chan.data.pressed_mask[LIMIT-1:0];
                     layer_in = 2'd0;
                     slot_in  = '0;
                     for (int i = 0; i < SLOTS; i++) begin
                        key_in[i] = 8'd0;
                     end
                  end
                  FUNC_KEYMAP: begin
                     km_we = (int'(req_chan.data.table_layer) < LAYERS)
                             && (int'(req_chan.data.table_key) < NKEYS);
                  end
                  FUNC_LAYER_SW: begin
                     ls_we = int'(req_chan.data.table_key) < NKEYS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LS: begin
            // returned layer-switch entry of the previous position
            if (pend_ff) begin
               if (pressed_ff) begin
                  layer_in = layer_ff | ls_q_ff;
               end
               ord_in            = ord_ff >> 1;
               ord_in[LIMIT-1]   = pressed_ff && (ls_q_ff == 2'd0);
            end
            if (int'(cnt_ff) < LIMIT) begin
               pend_in    = 1'b1;
               pressed_in = mask_ff[0];
               mask_in    = mask_ff >> 1;
               cnt_in     = cnt_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_KM;
               cnt_in   = '0;
            end
         end
         S_KM: begin
            if (pend_ff && (int'(slot_ff) < SLOTS)) begin
               key_in[slot_ff] = code;
               slot_in         = slot_ff + 1'b1;
            end
            if (int'(cnt_ff) < LIMIT) begin
               pend_in = ord_ff[0];
               zero_in = !layer_ok;
               ord_in  = ord_ff >> 1;
               cnt_in  = cnt_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.key_0        = key_ff[0];
               rsp_data_in.key_1        = key_ff[1];
               rsp_data_in.key_2        = key_ff[2];
               rsp_data_in.key_3        = key_ff[3];
               rsp_data_in.key_4        = key_ff[4];
               rsp_data_in.key_5        = key_ff[5];
               rsp_data_in.active_layer = layer_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // keymap and layer-switch memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (km_we) begin
         km_mem_ff[km_waddr] <= km_wdata;
      end
      if (ls_we) begin
         ls_mem_ff[ls_waddr] <= ls_wdata;
      end
      km_q_ff <= km_mem_ff[km_raddr];
      ls_q_ff <= ls_mem_ff[ls_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      ord_ff      <= ord_in;
      layer_ff    <= layer_in;
      pressed_ff  <= pressed_in;
      zero_ff     <= zero_in;
      slot_ff     <= slot_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/key_matrix_layer_report_top_tb.sv]
// self-checking testbench of the key matrix layer report block
module key_matrix_layer_report_top_tb
   import kmlr_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NKEYS       = 16;
   localparam int          NLAYERS     = 4;
   localparam int          RANDOM_ITEMS = 1000;
   localparam int          IDLE_LIMIT  = 2000;
   localparam int          TAIL_CYCLES = 64;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;

   typedef struct {
      req_type data;
      bit      drain;
   } pending_item_type;

   logic clock = 1'b0;
   logic reset;

   kmlr_req_if req_chan ();
   kmlr_rsp_if rsp_chan ();

   key_matrix_layer_report_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   pending_item_type pending_items[$];
   rsp_type       expected_reports[$];
   logic [7:0]    keymap_copy [NLAYERS][NKEYS];
   logic [1:0]    layer_sw_copy [NKEYS];
   int unsigned   error_count = 0;
   int unsigned   send_gap;
   int unsigned   send_calm = 0;
   int unsigned   recv_stall;
   int unsigned   recv_calm = 0;
   int unsigned   idle_cycles;

   // pause before the next item, with occasional runs of back-to-back items
   function automatic int unsigned draw_pause(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 11);
   endfunction

   // updates the table copies; gives 1 and the report for a scan item
   function automatic bit predict_report(input req_type r, output rsp_type rep);
      logic [1:0]  layer;
      logic [7:0]  codes [SLOTS];
      int unsigned used;
      rep = '0;
      layer = 2'd0;
      used = 0;
      case (r.func)
         FUNC_KEYMAP: begin
            keymap_copy[r.table_layer][r.table_key] = r.table_value;
            return 1'b0;
         end
         FUNC_LAYER_SW: begin
            layer_sw_copy[r.table_key] = r.table_value[1:0];
            return 1'b0;
         end
         FUNC_SCAN: ;
         default: return 1'b0;
      endcase
      for (int i = 0; i < SLOTS; i++) codes[i] = 8'd0;
      for (int p = 0; p < NKEYS; p++) begin
         if (r.pressed_mask[p]) layer = layer | layer_sw_copy[p];
      end
      for (int p = 0; p < NKEYS; p++) begin
         if (r.pressed_mask[p] && layer_sw_copy[p] == 2'd0 && used < SLOTS) begin
            codes[used] = keymap_copy[layer][p];
            used++;
         end
      end
      rep.key_0 = codes[0];
      rep.key_1 = codes[1];
      rep.key_2 = codes[2];
      rep.key_3 = codes[3];
      rep.key_4 = codes[4];
      rep.key_5 = codes[5];
      rep.active_layer = layer;
      return 1'b1;
   endfunction

   task automatic add_item(input logic [1:0] func, input logic [15:0] mask,
                           input logic [1:0] tlayer, input logic [3:0] tkey,
                           input logic [7:0] tval, input bit drain = 1'b0);
      pending_item_type it;
      it.data.func = func;
      it.data.pressed_mask = mask;
      it.data.table_layer = tlayer;
      it.data.table_key = tkey;
      it.data.table_value = tval;
      it.drain = drain;
      pending_items.push_back(it);
   endtask

   task automatic add_scan(input logic [15:0] mask, input bit drain = 1'b0);
      add_item(FUNC_SCAN, mask, 2'($urandom), 4'($urandom), 8'($urandom), drain);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   function automatic logic [15:0] draw_mask();
      logic [15:0] m;
      m = 16'd0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            for (int i = $urandom_range(1, 4); i > 0; i--) m[$urandom_range(0, 15)] = 1'b1;
         end
         4, 5, 6: m = 16'($urandom);
         7: m = 16'hFFFF;
         8: m = 16'd0;
         default: m = 16'($urandom) & 16'($urandom);
      endcase
      return m;
   endfunction

   // driver: predicts on acceptance, then offers the next item after its pause
   always @(posedge clock) begin
      rsp_type rep;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.data <= '0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (predict_report(req_chan.data, rep)) expected_reports.push_back(rep);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               req_chan.valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && expected_reports.size() != 0)) begin
               req_chan.data <= pending_items[0].data;
               req_chan.valid <= 1'b1;
               send_gap <= draw_pause(send_calm);
               void'(pending_items.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each report against the oldest prediction
   always @(posedge clock) begin
      rsp_type     want;
      int unsigned wait_left;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         wait_left = recv_stall;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t ns: unexpected report, expected none, actual %h",
                        $time, rsp_chan.data);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("key_0", 32'(want.key_0), 32'(rsp_chan.data.key_0));
               check_field("key_1", 32'(want.key_1), 32'(rsp_chan.data.key_1));
               check_field("key_2", 32'(want.key_2), 32'(rsp_chan.data.key_2));
               check_field("key_3", 32'(want.key_3), 32'(rsp_chan.data.key_3));
               check_field("key_4", 32'(want.key_4), 32'(rsp_chan.data.key_4));
               check_field("key_5", 32'(want.key_5), 32'(rsp_chan.data.key_5));
               check_field("active_layer", 32'(want.active_layer),
                           32'(rsp_chan.data.active_layer));
            end
            wait_left = draw_pause(recv_calm);
         end
         if (wait_left != 0) begin
            rsp_chan.ready <= 1'b0;
            recv_stall <= wait_left - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
            recv_stall <= 0;
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_chan.valid && req_chan.ready) ||
                   (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned pick;
      logic [7:0]  val;
      reset = 1'b1;
      for (int l = 0; l < NLAYERS; l++)
         for (int k = 0; k < NKEYS; k++) keymap_copy[l][k] = 8'd0;
      for (int k = 0; k < NKEYS; k++) layer_sw_copy[k] = 2'd0;

      // tables straight after reset read as zero
      add_scan(16'h0000);
      add_scan(16'hFFFF);
      add_item(FUNC_KEYMAP, 16'hFFFF, 2'd0, 4'd0, 8'hFF);
      add_item(FUNC_KEYMAP, 16'h0000, 2'd3, 4'd15, 8'h01);
      add_item(FUNC_KEYMAP, 16'h1234, 2'd1, 4'd5, 8'h80);
      add_item(FUNC_KEYMAP, 16'h8421, 2'd3, 4'd0, 8'h5A);
      add_item(FUNC_KEYMAP, 16'h0F0F, 2'd2, 4'd1, 8'hA5);
      // only the low bits of a layer-switch value are kept
      add_item(FUNC_LAYER_SW, 16'h0000, 2'd3, 4'd15, 8'hFF);
      add_item(FUNC_LAYER_SW, 16'hFFFF, 2'd0, 4'd14, 8'hFD);
      add_item(FUNC_LAYER_SW, 16'hAAAA, 2'd1, 4'd13, 8'h02);
      // unused func code is ignored
      add_item(FUNC_UNUSED, 16'hFFFF, 2'd3, 4'd15, 8'hFF);
      add_item(FUNC_UNUSED, 16'h0000, 2'd0, 4'd0, 8'h00);
      add_scan(16'h8001);
      add_scan(16'h0001);
      add_scan(16'h4020);
      add_scan(16'h6003);
      // more than six ordinary keys, extra ones dropped
      add_scan(16'h1FFF, 1'b1);
      add_scan(16'hFFFF);
      add_item(FUNC_LAYER_SW, 16'h0000, 2'd2, 4'd14, 8'h00);
      add_item(FUNC_LAYER_SW, 16'h0000, 2'd2, 4'd13, 8'hFC);
      add_scan(16'h4003);
      add_scan(16'h0000);
      add_item(FUNC_LAYER_SW, 16'h0000, 2'd0, 4'd15, 8'h00);
      add_scan(16'hFFFF, 1'b1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 18) begin
            add_item(FUNC_KEYMAP, 16'($urandom), 2'($urandom), 4'($urandom), 8'($urandom));
         end else if (pick < 26) begin
            // mostly ordinary keys so that reports stay well filled
            val = 8'($urandom);
            if ($urandom_range(0, 9) < 6) val[1:0] = 2'd0;
            add_item(FUNC_LAYER_SW, 16'($urandom), 2'($urandom), 4'($urandom), val);
         end else if (pick < 30) begin
            add_item(FUNC_UNUSED, 16'($urandom), 2'($urandom), 4'($urandom), 8'($urandom));
         end else begin
            add_scan(draw_mask(), n == 300 || n == 700);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[key_matrix_layer_report_top.f]
rtl/kmlr_pkg.sv
rtl/kmlr_req_if.sv
rtl/kmlr_rsp_if.sv
rtl/key_matrix_layer_report_top.sv
tb/key_matrix_layer_report_top_tb.sv
